// ===== rtl/core/frot_pkg.sv =====
// Shared types and codes for the frame rotation block.
package frot_pkg;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned POS_W  = 2 * SIZE_W;

  // Item kinds carried in the input tuser bit.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Result status carried in the output tuser bit.
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SOURCE_ROWS    = 1'b0;
  localparam logic REG_SOURCE_COLUMNS = 1'b1;

  typedef struct packed {
    logic wr_en;     // store the accepted load item
    logic rd_en;     // read the store for the accepted fetch item
    logic err_set;   // accepted item meets an empty frame
    logic out_load;  // move the pending result into the output register
  } frot_cmd_t;

  typedef struct packed {
    logic empty;     // rows or columns are zero
    logic out_free;  // output register can take a result this cycle
  } frot_stat_t;

endpackage

// ===== rtl/core/frot_ram.sv =====
// Generic single-port RAM with registered read data.
module frot_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/frot_ctrl.sv =====
// Controller: sequences item acceptance and result hand-off.
module frot_ctrl
  import frot_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       opcode_i,
  input  frot_stat_t stat_i,
  output logic       in_ready_o,
  output frot_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  logic accept;

  always_comb begin
    accept         = in_valid_i && (state_q == ST_IDLE);
    cmd_o.wr_en    = accept && !stat_i.empty && (opcode_i == OP_LOAD);
    cmd_o.rd_en    = accept && !stat_i.empty && (opcode_i == OP_FETCH);
    cmd_o.err_set  = accept && stat_i.empty;
    cmd_o.out_load = (state_q == ST_BUSY) && stat_i.out_free;
    state_d        = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.rd_en || cmd_o.err_set) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/core/frot_dp.sv =====
// Datapath: size registers, position counters, frame store and output register.
module frot_dp
  import frot_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 128,
  parameter int unsigned MAX_COLUMNS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]  pix_i,
  input  frot_cmd_t         cmd_i,
  input  logic              out_ready_i,
  output frot_stat_t        stat_o,
  output logic              out_valid_o,
  output logic [PIX_W-1:0]  out_pix_o,
  output logic              out_last_o,
  output logic              out_status_o
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [12:0] MAX_R  = 13'(MAX_ROWS);
  localparam logic [12:0] MAX_C  = 13'(MAX_COLUMNS);

  logic [SIZE_W-1:0] rows_q, cols_q;
  logic [SIZE_W-1:0] load_row_q, load_row_d, load_col_q, load_col_d;
  logic [POS_W-1:0]  read_pos_q, read_pos_d;
  logic              last_q, err_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_last_q, out_status_q;

  logic [SIZE_W-1:0] rows, cols, r, c;
  logic [SIZE_W:0]   r_inc, c_inc;
  logic [POS_W-1:0]  total, pos, load_addr;
  logic [POS_W:0]    pos_inc;
  logic              last;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  // Saturate the size registers at the store geometry.
  always_comb begin
    rows  = ({5'b0, rows_q} > MAX_R) ? MAX_R[SIZE_W-1:0] : rows_q;
    cols  = ({5'b0, cols_q} > MAX_C) ? MAX_C[SIZE_W-1:0] : cols_q;
    total = {{SIZE_W{1'b0}}, rows} * {{SIZE_W{1'b0}}, cols};

    r     = (load_row_q < rows) ? load_row_q : rows - 1'b1;
    c     = (load_col_q < cols) ? load_col_q : cols - 1'b1;
    r_inc = {1'b0, r} + 1'b1;
    c_inc = {1'b0, c} + 1'b1;
    // Source pixel (r, c) lands at rotated row c, column rows-1-r.
    load_addr = ({{SIZE_W{1'b0}}, c} * {{SIZE_W{1'b0}}, rows}) +
                {{SIZE_W{1'b0}}, rows - 1'b1 - r};

    pos     = (read_pos_q < total) ? read_pos_q : '0;
    pos_inc = {1'b0, pos} + 1'b1;
    last    = (pos_inc >= {1'b0, total});

    load_row_d = load_row_q;
    load_col_d = load_col_q;
    if (cmd_i.wr_en) begin
      if (c_inc >= {1'b0, cols}) begin
        load_col_d = '0;
        load_row_d = (r_inc >= {1'b0, rows}) ? '0 : r_inc[SIZE_W-1:0];
      end else begin
        load_col_d = c_inc[SIZE_W-1:0];
        load_row_d = r;
      end
    end

    read_pos_d = read_pos_q;
    if (cmd_i.rd_en) begin
      read_pos_d = last ? '0 : pos_inc[POS_W-1:0];
    end

    ram_addr = cmd_i.wr_en ? ADDR_W'(load_addr) : ADDR_W'(pos);
  end

  frot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .re_i    (cmd_i.rd_en),
    .addr_i  (ram_addr),
    .wdata_i (pix_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= '0;
      cols_q     <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
      read_pos_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOURCE_ROWS:    rows_q <= cfg_data_i;
        REG_SOURCE_COLUMNS: cols_q <= cfg_data_i;
        default:            rows_q <= rows_q;
      endcase
      // A new size restarts the frame.
      load_row_q <= '0;
      load_col_q <= '0;
      read_pos_q <= '0;
    end else begin
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      read_pos_q <= read_pos_d;
    end
  end

  // Pending result flags, taken alongside the store read or an empty-frame error.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en || cmd_i.err_set) begin
      last_q <= last && cmd_i.rd_en;
      err_q  <= cmd_i.err_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pix_q    <= err_q ? '0 : ram_rdata;
      out_last_q   <= err_q ? 1'b0 : last_q;
      out_status_q <= err_q ? STAT_EMPTY : STAT_OK;
    end
  end

  assign stat_o.empty    = (rows == '0) || (cols == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_pix_o       = out_pix_q;
  assign out_last_o      = out_last_q;
  assign out_status_o    = out_status_q;

endmodule

// ===== rtl/core/frame_rotate_90_clockwise_top.sv =====
// Top level of the 90-degree clockwise frame rotation block.
// Load items are taken one per cycle while no result is pending, and are written straight
// into the frame store. A fetch item reads the store into its read register, an empty-frame item
// sets the pending error flag; no new item is taken until that result enters the output register.
// The input waits while a result is held back by output backpressure.
// Asynchronous active-low reset clears sizes, counters and handshake state; the
// store has no clearing pass, its entries are undefined until loaded.
module frame_rotate_90_clockwise_top
  import frot_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 128,
  parameter int unsigned MAX_COLUMNS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  logic              s_axis_tuser,   // opcode
  // Output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // red_out, green_out, blue_out
  output logic              m_axis_tlast,   // last_pixel
  output logic              m_axis_tuser    // status
);

  frot_cmd_t  cmd;
  frot_stat_t stat;

  // Sequence the handshake; the datapath only follows commands.
  frot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // Hold sizes, counters, the frame store and the output register.
  frot_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix_i        (s_axis_tdata),
    .cmd_i        (cmd),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_pix_o    (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

  // An empty-frame result carries no pixel and no last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_EMPTY)) |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("empty-frame result carries pixel data");

  // A fetch item blocks the input for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FETCH)) |=> !s_axis_tready)
    else $error("input taken while a fetch is in flight");

  // A load item on a non-empty frame never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD) && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("load item produced a result");

  // The input must have been not ready in the cycle before a result appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a pending item");

endmodule

// ===== tb/tb_frame_rotate_90_clockwise_top.sv =====
// Self-checking testbench for the 90-degree clockwise frame rotation block.
`timescale 1ns / 1ps

module tb_frame_rotate_90_clockwise_top;
  import frot_pkg::*;

  localparam int unsigned MAX_ROWS     = 128;
  localparam int unsigned MAX_COLUMNS  = 128;
  localparam int unsigned STORE_DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned DRAIN_CYCLES = 4;     // settle time after every owed result has arrived
  localparam int unsigned STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS  = 10;

  // One rotated pixel as it leaves the block.
  typedef struct {
    logic [PIX_W-1:0] pix;    // red [7:0], green [15:8], blue [23:16]
    logic             last;
    logic             status;
  } rotated_pixel_t;

  // Rotation predictor plus the queue of rotated pixels still owed by the block.
  class rotate_scoreboard;
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    int unsigned       load_row;
    int unsigned       load_col;
    int unsigned       read_pos;
    logic [PIX_W-1:0]  store [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    rotated_pixel_t    owed_q [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       loads;
    int unsigned       fetches;
    int unsigned       empties;

    function int unsigned eff_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    endfunction

    function int unsigned eff_cols();
      return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg;
    endfunction

    function bit frame_empty();
      return (eff_rows() == 0) || (eff_cols() == 0);
    endfunction

    // A fetch is only legal once the entry it reads has been loaded under this geometry.
    function bit fetch_ready();
      int unsigned total;
      total = eff_rows() * eff_cols();
      if (total == 0) return 1'b1;
      return written[(read_pos < total) ? read_pos : 0];
    endfunction

    // Any size write restarts the frame; forget what was loaded before.
    function void write_register(logic idx, logic [SIZE_W-1:0] val);
      if (idx == REG_SOURCE_ROWS) rows_reg = val;
      else                        cols_reg = val;
      load_row = 0;
      load_col = 0;
      read_pos = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void note_input(logic op, logic [PIX_W-1:0] pix);
      int unsigned    rows;
      int unsigned    cols;
      int unsigned    total;
      int unsigned    pos;
      int unsigned    addr;
      rotated_pixel_t res;
      rows  = eff_rows();
      cols  = eff_cols();
      total = rows * cols;
      if (total == 0) begin
        res.pix    = '0;
        res.last   = 1'b0;
        res.status = STAT_EMPTY;
        owed_q.push_back(res);
        empties++;
        return;
      end
      if (op == OP_LOAD) begin
        // Source (r, c) lands at rotated row c, column R-1-r.
        addr = load_col * rows + (rows - 1 - load_row);
        store[addr]   = pix;
        written[addr] = 1'b1;
        if (load_col + 1 >= cols) begin
          load_col = 0;
          load_row = (load_row + 1 >= rows) ? 0 : load_row + 1;
        end else begin
          load_col++;
        end
        loads++;
      end else begin
        pos        = (read_pos < total) ? read_pos : 0;
        res.pix    = store[pos];
        res.last   = (pos + 1 >= total);
        res.status = STAT_OK;
        read_pos   = res.last ? 0 : pos + 1;
        owed_q.push_back(res);
        fetches++;
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic last, logic status);
      rotated_pixel_t exp_pix;
      bit             bad;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result r=%h g=%h b=%h last=%b status=%b", $realtime,
                   pix[7:0], pix[15:8], pix[23:16], last, status);
        return;
      end
      exp_pix = owed_q.pop_front();
      checked++;
      bad = (pix[7:0] !== exp_pix.pix[7:0]) || (pix[15:8] !== exp_pix.pix[15:8]) ||
            (pix[23:16] !== exp_pix.pix[23:16]) || (last !== exp_pix.last) ||
            (status !== exp_pix.status);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch, expected r=%h g=%h b=%h last=%b status=%b, ",
                    "got r=%h g=%h b=%h last=%b status=%b"},
                   $realtime, exp_pix.pix[7:0], exp_pix.pix[15:8], exp_pix.pix[23:16],
                   exp_pix.last, exp_pix.status, pix[7:0], pix[15:8], pix[23:16], last, status);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [SIZE_W-1:0] cfg_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata;   // red_in, green_in, blue_in
  logic              s_axis_tuser;   // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [PIX_W-1:0]  m_axis_tdata;   // red_out, green_out, blue_out
  logic              m_axis_tlast;   // last_pixel
  logic              m_axis_tuser;   // status

  rotate_scoreboard sb;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      stall_cycles;
  int unsigned      frame_setups;

  frame_rotate_90_clockwise_top #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Randomly hold off the output side; changes land on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Sample every handshake at the rising edge, in one place so the predictor
  // sees register writes, accepted items and results in a fixed order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_register(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      // Watchdog: give up when nothing moves for too long.
      if (cfg_we_i || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the item was taken,
  // so the predictor already holds it when the next item is chosen.
  task automatic send_item(logic op, logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Resize the frame while the block is idle, in random register order.
  task automatic set_frame(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_SOURCE_ROWS, rows);
      write_reg(REG_SOURCE_COLUMNS, cols);
    end else begin
      write_reg(REG_SOURCE_COLUMNS, cols);
      write_reg(REG_SOURCE_ROWS, rows);
    end
    frame_setups++;
  endtask

  // Fetch only where the rotated entry is loaded, else keep loading; an empty frame takes either kind.
  task automatic random_item();
    logic             op;
    logic [PIX_W-1:0] pix;
    pix = $urandom;
    if (sb.frame_empty())                       op = $urandom_range(0, 1) ? OP_FETCH : OP_LOAD;
    else if (sb.fetch_ready() && $urandom_range(0, 1)) op = OP_FETCH;
    else                                        op = OP_LOAD;
    send_item(op, pix);
  endtask

  initial begin
    int unsigned       random_items;
    int unsigned       n_items;
    int                pause_at;
    bit                rows_sat_done;
    bit                cols_sat_done;
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;

    sb            = new;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SOURCE_ROWS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 59;
    stall_cycles  = 0;
    frame_setups  = 0;
    random_items  = 0;
    rows_sat_done = 1'b0;
    cols_sat_done = 1'b0;
    sb.rows_reg   = '0;
    sb.cols_reg   = '0;
    sb.load_row   = 0;
    sb.load_col   = 0;
    sb.read_pos   = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: sizes are zero after reset, so both kinds report an empty frame.
    send_item(OP_LOAD, 24'hFFFFFF);
    send_item(OP_FETCH, 24'h000000);

    // Small 2x3 frame with extreme and alternating pixel values, read out fully.
    set_frame(8'd2, 8'd3);
    send_item(OP_LOAD, 24'h000000);
    send_item(OP_LOAD, 24'hFFFFFF);
    send_item(OP_LOAD, 24'hA5A5A5);
    send_item(OP_LOAD, 24'h5A5A5A);
    send_item(OP_LOAD, 24'h0000FF);
    send_item(OP_LOAD, 24'hFF0000);
    repeat (6) send_item(OP_FETCH, 24'hFFFFFF);

    // Single-pixel frame: every fetch is the last one and the counter wraps.
    set_frame(8'd1, 8'd1);
    send_item(OP_LOAD, 24'h123456);
    send_item(OP_FETCH, 24'h000000);
    send_item(OP_FETCH, 24'h000000);

    // One dimension zero, the other set: still an empty frame.
    set_frame(8'd0, 8'd5);
    send_item(OP_LOAD, 24'h00FF00);
    send_item(OP_FETCH, 24'h00FF00);
    set_frame(8'd5, 8'd0);
    send_item(OP_FETCH, 24'hFFFFFF);

    // Random frames; the idle mix changes by thirds of the run.
    while (random_items < RANDOM_ITEMS) begin
      if (!rows_sat_done && random_items >= 60) begin
        // Row count above the store limit saturates to 128.
        rows          = 8'd255;
        cols          = 8'd1;
        n_items       = 150;
        rows_sat_done = 1'b1;
      end else if (!cols_sat_done && random_items >= 260) begin
        rows          = 8'd1;
        cols          = 8'(128 + $urandom_range(1, 127));
        n_items       = 150;
        cols_sat_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        rows    = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
        cols    = (rows == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        n_items = 6;
      end else begin
        rows    = 8'($urandom_range(1, 6));
        cols    = 8'($urandom_range(1, 6));
        n_items = 2 * rows * cols + $urandom_range(0, 3);
      end
      set_frame(rows, cols);
      pause_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, n_items - 1)) : -1;
      for (int i = 0; i < n_items; i++) begin
        case (random_items * 3 / RANDOM_ITEMS)
          0: begin
            send_idle_pct = 18;
            recv_idle_pct = 59;
          end
          1: begin
            send_idle_pct = 59;
            recv_idle_pct = 18;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        // Hold the sender mid-frame until the block has caught up.
        if (i == pause_at) drain();
        random_item();
        random_items++;
      end
    end

    drain();
    $display("Run covered %0d loads, %0d fetches and %0d empty-frame items",
             sb.loads, sb.fetches, sb.empties);
    $display("over %0d frame sizes, with saturated row and column counts; %0d results compared.",
             frame_setups, sb.checked);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.owed_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/frot_pkg.sv
rtl/core/frot_ram.sv
rtl/core/frot_ctrl.sv
rtl/core/frot_dp.sv
rtl/core/frame_rotate_90_clockwise_top.sv
tb/tb_frame_rotate_90_clockwise_top.sv
